// ----- rtl/quaternion_to_euler_unit_macros.svh -----
// ---------------------------------------------------------------------------
// quaternion to euler unit assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_UNIT_MACROS_SVH
`define QUATERNION_TO_EULER_UNIT_MACROS_SVH
`ifndef SYNTH
`define Q2E_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("q2e assertion failed");
`define Q2E_ASSERT_IMPL(lbl, pre, post) \
  `Q2E_ASSERT(lbl, (pre) |-> (post))
`else
`define Q2E_ASSERT(lbl, prop)
`define Q2E_ASSERT_IMPL(lbl, pre, post)
`endif
`endif

// ----- rtl/q2e_pkg.sv -----
// ---------------------------------------------------------------------------
// q2e_pkg
// widths, constants, data words and arctangent table of the euler unit
// ---------------------------------------------------------------------------
`default_nettype none
package q2e_pkg;

  localparam int ZW        = 35;  // products, angle accumulator
  localparam int XW        = 44;  // normalized vector components
  localparam int NORM_TOP  = 41;  // normalized magnitude below 2^41
  localparam int TABLE_LEN = 24;
  localparam int SQRT_STEPS = 32;
  localparam int NORM_STAGES = 6;

  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam logic [63:0] ONE_Q30  = 64'd1073741824;
  localparam logic [63:0] ONE_Q60  = 64'd1 << 60;
  localparam int          ANG_LIMIT   = 25736;
  localparam int          HALF_PI_OUT = 12868;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic        [XW-1:0] m;
    logic                 zero;
  } norm_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } rot_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [ZW-1:0] sinr;
    logic signed [ZW-1:0] cosr;
    logic signed [ZW-1:0] siny;
    logic signed [ZW-1:0] cosy;
    logic signed [ZW-1:0] sinp;
  } terms_t;

  typedef struct packed {
    logic sat;
    logic pos;
  } pflag_t;

  // atan(2^-i) * 2^30, truncated
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = ZW'(64'd843314856);
      1:  r = ZW'(64'd497837829);
      2:  r = ZW'(64'd263043836);
      3:  r = ZW'(64'd133525158);
      4:  r = ZW'(64'd67021686);
      5:  r = ZW'(64'd33543515);
      6:  r = ZW'(64'd16775850);
      7:  r = ZW'(64'd8388437);
      8:  r = ZW'(64'd4194282);
      9:  r = ZW'(64'd2097149);
      10: r = ZW'(64'd1048575);
      11: r = ZW'(64'd524287);
      12: r = ZW'(64'd262143);
      13: r = ZW'(64'd131071);
      14: r = ZW'(64'd65535);
      15: r = ZW'(64'd32767);
      16: r = ZW'(64'd16383);
      17: r = ZW'(64'd8191);
      18: r = ZW'(64'd4095);
      19: r = ZW'(64'd2047);
      20: r = ZW'(64'd1023);
      21: r = ZW'(64'd511);
      22: r = ZW'(64'd255);
      23: r = ZW'(64'd127);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/quaternion_to_euler_unit.sv -----
// ---------------------------------------------------------------------------
// quaternion_to_euler_unit
// pipeline: products, trig terms, square, remainder, root row, lane, output register
// throughput: one quaternion word per cycle, busy is always low
// the deepest parts are the 32-step square root row and the cordic cell row
// reset clears only the valid line; the result strobe cannot be stalled
// ---------------------------------------------------------------------------
`default_nettype none
`include "quaternion_to_euler_unit_macros.svh"
module quaternion_to_euler_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  output logic                    valid_o,
  output logic signed [15:0]      roll_angle_o,
  output logic signed [14:0]      pitch_angle_o,
  output logic signed [15:0]      yaw_angle_o
);

  localparam int ZW       = q2e_pkg::ZW;
  localparam int NUM_ITER = (CORDIC_STEPS > q2e_pkg::TABLE_LEN) ? q2e_pkg::TABLE_LEN
                                                                 : CORDIC_STEPS;
  // products, sums, square, remainder, root row, lane, output register
  localparam int LAT      = 4 + q2e_pkg::SQRT_STEPS + q2e_pkg::NORM_STAGES + 1
                            + NUM_ITER + 1;
  localparam int DLY      = q2e_pkg::SQRT_STEPS + 2;
  localparam int FLAG_DLY = LAT - 3;

  // start-to-result valid line
  logic [LAT-1:0] vld_d, vld_q;
  logic           accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    vld_d = {vld_q[LAT-2:0], accept};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign valid_o = vld_q[LAT-1];

  // stage 1: the nine component products
  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_zz_q;
  logic signed [31:0] p_wy_q, p_zx_q, p_wz_q, p_xy_q;

  always_ff @(posedge clk_i) begin
    p_wx_q <= quat_w_i * quat_x_i;
    p_yz_q <= quat_y_i * quat_z_i;
    p_xx_q <= quat_x_i * quat_x_i;
    p_yy_q <= quat_y_i * quat_y_i;
    p_zz_q <= quat_z_i * quat_z_i;
    p_wy_q <= quat_w_i * quat_y_i;
    p_zx_q <= quat_z_i * quat_x_i;
    p_wz_q <= quat_w_i * quat_z_i;
    p_xy_q <= quat_x_i * quat_y_i;
  end

  // stage 2: the five trig terms in q30, exact
  q2e_pkg::terms_t terms_d, terms_q;
  logic signed [ZW-1:0] one_q30;

  assign one_q30 = $signed(ZW'(q2e_pkg::ONE_Q30));

  always_comb begin
    terms_d.sinr = (ZW'(p_wx_q) + ZW'(p_yz_q)) <<< 1;
    terms_d.cosr = one_q30 - ((ZW'(p_xx_q) + ZW'(p_yy_q)) <<< 1);
    terms_d.sinp = (ZW'(p_wy_q) - ZW'(p_zx_q)) <<< 1;
    terms_d.siny = (ZW'(p_wz_q) + ZW'(p_xy_q)) <<< 1;
    terms_d.cosy = one_q30 - ((ZW'(p_yy_q) + ZW'(p_zz_q)) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    terms_q <= terms_d;
  end

  // stage 3: pitch term squared and its saturation flags
  logic signed [30:0]   sp;
  logic signed [61:0]   sq_full;
  logic [61:0]          sq_q;
  logic signed [ZW-1:0] sinp_mag;
  q2e_pkg::pflag_t      flag_d;

  always_comb begin
    sp       = terms_q.sinp[30:0];
    sq_full  = sp * sp;
    sinp_mag = terms_q.sinp[ZW-1] ? -terms_q.sinp : terms_q.sinp;
    flag_d.sat = (sinp_mag >= one_q30);
    flag_d.pos = !terms_q.sinp[ZW-1] && (terms_q.sinp != '0);
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_full;
  end

  // stage 4: 1 - sinp^2 in q60
  q2e_pkg::sqrt_t root [q2e_pkg::SQRT_STEPS+1];
  q2e_pkg::sqrt_t rem_q;

  always_ff @(posedge clk_i) begin
    rem_q.v   <= q2e_pkg::ONE_Q60 - 64'(sq_q);
    rem_q.res <= '0;
  end

  assign root[0] = rem_q;

  // square root row, one result bit per cell
  for (genvar k = 0; k < q2e_pkg::SQRT_STEPS; k++) begin : g_sqrt
    q2e_sqrt_cell #(.STAGE(k)) u_sqrt (
      .clk_i  (clk_i),
      .data_i (root[k]),
      .data_o (root[k+1])
    );
  end

  // terms wait alongside the root row
  q2e_pkg::terms_t dl_q [DLY];

  always_ff @(posedge clk_i) begin
    dl_q[0] <= terms_q;
    for (int i = 1; i < DLY; i++) begin
      dl_q[i] <= dl_q[i-1];
    end
  end

  // pitch flags wait until the output register
  q2e_pkg::pflag_t fl_q [FLAG_DLY];

  always_ff @(posedge clk_i) begin
    fl_q[0] <= flag_d;
    for (int i = 1; i < FLAG_DLY; i++) begin
      fl_q[i] <= fl_q[i-1];
    end
  end

  // three arctangent lanes
  logic signed [ZW-1:0] cos_p;
  logic signed [ZW-1:0] z_roll, z_pitch, z_yaw;

  assign cos_p = $signed(ZW'(root[q2e_pkg::SQRT_STEPS].res[30:0]));

  q2e_atan_lane #(.NUM_ITER(NUM_ITER)) u_roll (
    .clk_i (clk_i),
    .y_i   (dl_q[DLY-1].sinr),
    .x_i   (dl_q[DLY-1].cosr),
    .z_o   (z_roll)
  );

  q2e_atan_lane #(.NUM_ITER(NUM_ITER)) u_pitch (
    .clk_i (clk_i),
    .y_i   (dl_q[DLY-1].sinp),
    .x_i   (cos_p),
    .z_o   (z_pitch)
  );

  q2e_atan_lane #(.NUM_ITER(NUM_ITER)) u_yaw (
    .clk_i (clk_i),
    .y_i   (dl_q[DLY-1].siny),
    .x_i   (dl_q[DLY-1].cosy),
    .z_o   (z_yaw)
  );

  // round half up to 13 fraction bits, then clamp
  function automatic logic signed [15:0] fix_angle(input logic signed [ZW-1:0] z,
                                                   input int limit);
    logic signed [ZW:0] s;
    logic signed [ZW:0] r;
    logic signed [ZW:0] lim;
    s   = (ZW+1)'(z) + $signed((ZW+1)'(65536));
    r   = s >>> 17;
    lim = $signed((ZW+1)'(limit));
    if (r > lim) begin
      r = lim;
    end
    if (r < -lim) begin
      r = -lim;
    end
    return r[15:0];
  endfunction

  logic signed [15:0] roll_d, yaw_d, pitch_r;
  logic signed [14:0] pitch_d;

  always_comb begin
    roll_d  = fix_angle(z_roll, q2e_pkg::ANG_LIMIT);
    yaw_d   = fix_angle(z_yaw, q2e_pkg::ANG_LIMIT);
    pitch_r = fix_angle(z_pitch, q2e_pkg::HALF_PI_OUT);
    if (fl_q[FLAG_DLY-1].sat) begin
      pitch_d = fl_q[FLAG_DLY-1].pos ? 15'(q2e_pkg::HALF_PI_OUT)
                                     : -15'(q2e_pkg::HALF_PI_OUT);
    end else begin
      pitch_d = pitch_r[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    roll_angle_o  <= roll_d;
    pitch_angle_o <= pitch_d;
    yaw_angle_o   <= yaw_d;
  end

  // fixed latency, pitch and roll output ranges
  `Q2E_ASSERT(a_latency, accept |-> ##LAT valid_o)
  `Q2E_ASSERT_IMPL(a_pitch_rng, valid_o,
    pitch_angle_o <= 15'sd12868 && pitch_angle_o >= -15'sd12868)
  `Q2E_ASSERT_IMPL(a_roll_rng, valid_o,
    roll_angle_o <= 16'sd25736 && roll_angle_o >= -16'sd25736)

endmodule
`default_nettype wire

// ----- rtl/q2e_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// q2e_sqrt_cell
// one registered bit step of the integer square root
// ---------------------------------------------------------------------------
`default_nettype none
module q2e_sqrt_cell #(
  parameter int STAGE = 0
) (
  input  wire logic            clk_i,
  input  wire q2e_pkg::sqrt_t  data_i,
  output q2e_pkg::sqrt_t       data_o
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STAGE);

  q2e_pkg::sqrt_t data_d, data_q;
  logic [63:0]    trial;

  always_comb begin
    trial = data_i.res + BIT;
    if (data_i.v >= trial) begin
      data_d.v   = data_i.v - trial;
      data_d.res = (data_i.res >> 1) + BIT;
    end else begin
      data_d.v   = data_i.v;
      data_d.res = data_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ----- rtl/q2e_norm_cell.sv -----
// ---------------------------------------------------------------------------
// q2e_norm_cell
// conditional left shift by a fixed amount toward the normalized range
// ---------------------------------------------------------------------------
`default_nettype none
module q2e_norm_cell #(
  parameter int K = 1
) (
  input  wire logic            clk_i,
  input  wire q2e_pkg::norm_t  data_i,
  output q2e_pkg::norm_t       data_o
);

  localparam logic [q2e_pkg::XW-1:0] LIM = q2e_pkg::XW'(1) << (q2e_pkg::NORM_TOP - K);

  q2e_pkg::norm_t data_d, data_q;

  always_comb begin
    data_d = data_i;
    if (data_i.m < LIM) begin
      data_d.x = data_i.x <<< K;
      data_d.y = data_i.y <<< K;
      data_d.m = data_i.m << K;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ----- rtl/q2e_cordic_cell.sv -----
// ---------------------------------------------------------------------------
// q2e_cordic_cell
// one vectoring micro-rotation with its arctangent step
// ---------------------------------------------------------------------------
`default_nettype none
module q2e_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic           clk_i,
  input  wire q2e_pkg::rot_t  data_i,
  output q2e_pkg::rot_t       data_o
);

  localparam logic signed [q2e_pkg::ZW-1:0] ATAN = q2e_pkg::atan_q30(STEP);

  q2e_pkg::rot_t               data_d, data_q;
  logic signed [q2e_pkg::XW-1:0] dx, dy;

  always_comb begin
    dx     = data_i.y >>> STEP;
    dy     = data_i.x >>> STEP;
    data_d = data_i;
    if (!data_i.y[q2e_pkg::XW-1]) begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + ATAN;
    end else begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ----- rtl/q2e_atan_lane.sv -----
// ---------------------------------------------------------------------------
// q2e_atan_lane
// pipelined four-quadrant arctangent: normalize, fold, cordic cell row
// ---------------------------------------------------------------------------
`default_nettype none
module q2e_atan_lane #(
  parameter int NUM_ITER = 16
) (
  input  wire logic                              clk_i,
  input  wire logic signed [q2e_pkg::ZW-1:0]     y_i,
  input  wire logic signed [q2e_pkg::ZW-1:0]     x_i,
  output logic signed [q2e_pkg::ZW-1:0]          z_o
);

  localparam int NS = q2e_pkg::NORM_STAGES;
  localparam int XW = q2e_pkg::XW;
  localparam int ZW = q2e_pkg::ZW;

  q2e_pkg::norm_t nrm [NS+1];
  q2e_pkg::rot_t  rot [NUM_ITER+1];
  q2e_pkg::rot_t  fold_d, fold_q;
  logic [XW-1:0]  ax, ay;

  always_comb begin
    ax = x_i[ZW-1] ? XW'(-x_i) : XW'(x_i);
    ay = y_i[ZW-1] ? XW'(-y_i) : XW'(y_i);
    nrm[0].x    = XW'(y_i) == '0 ? XW'(x_i) : XW'(x_i);
    nrm[0].y    = XW'(y_i);
    nrm[0].m    = ax | ay;
    nrm[0].zero = (x_i == '0) && (y_i == '0);
  end

  for (genvar j = 0; j < NS; j++) begin : g_norm
    q2e_norm_cell #(.K(32 >> j)) u_norm (
      .clk_i  (clk_i),
      .data_i (nrm[j]),
      .data_o (nrm[j+1])
    );
  end

  // left half-plane folds onto the right with a start of +-pi
  always_comb begin
    fold_d.zero = nrm[NS].zero;
    if (nrm[NS].x[XW-1]) begin
      fold_d.x = -nrm[NS].x;
      fold_d.y = -nrm[NS].y;
      fold_d.z = nrm[NS].y[XW-1] ? -$signed(ZW'(q2e_pkg::PI_Q30))
                                 : $signed(ZW'(q2e_pkg::PI_Q30));
    end else begin
      fold_d.x = nrm[NS].x;
      fold_d.y = nrm[NS].y;
      fold_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    fold_q <= fold_d;
  end

  assign rot[0] = fold_q;

  for (genvar i = 0; i < NUM_ITER; i++) begin : g_cordic
    q2e_cordic_cell #(.STEP(i)) u_cell (
      .clk_i  (clk_i),
      .data_i (rot[i]),
      .data_o (rot[i+1])
    );
  end

  assign z_o = rot[NUM_ITER].zero ? '0 : rot[NUM_ITER].z;

endmodule
`default_nettype wire
